/* design/calendar_to_epoch_seconds_defines.svh */
// Assertion macros for the calendar to epoch seconds block.
// Included by the top level; no other dependencies.
`ifndef CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH
`define CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define C2E_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define C2E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/c2e_pkg.sv */
// Shared types, constants and tables for the calendar to epoch seconds block.
// No dependencies.
package c2e_pkg;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MONTH    = 3'd1,
    ERR_DAY      = 3'd2,
    ERR_HOUR     = 3'd3,
    ERR_MINUTE   = 3'd4,
    ERR_SECOND   = 3'd5,
    ERR_NEGATIVE = 3'd6
  } err_code_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        dst_active;
  } in_item_t;

  typedef struct packed {
    logic [36:0] epoch_seconds;
    err_code_t   error_code;
  } out_item_t;

  // intermediate result between the day count and the final sum
  typedef struct packed {
    logic [19:0]        day_count;
    logic signed [19:0] time_secs;
    err_code_t          code;
  } day_sum_t;

  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [11:0] CENTURY_BASE   = 12'd1900;
  localparam logic [11:0] TWO_DIGIT_LIM  = 12'd70;
  localparam logic [11:0] CENTURY_SPAN   = 12'd100;
  localparam logic [11:0] BASE_YY        = 12'd70;
  localparam logic [19:0] DAYS_PER_YEAR  = 20'd365;
  localparam logic [37:0] SECS_PER_DAY   = 38'd86400;
  localparam logic signed [19:0] SECS_PER_HOUR = 20'sd3600;
  localparam logic [19:0] SECS_PER_MIN   = 20'd60;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;
  localparam logic [5:0] MAX_SECOND = 6'd59;

  localparam logic signed [4:0] ZONE_RESET = -5'sd1;

  // days in the months before the given one, non-leap
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* design/c2e_in_if.sv */
// Request channel carrying one calendar date and time.
// Depends on c2e_pkg.
interface c2e_in_if;
  import c2e_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/c2e_out_if.sv */
// Result channel carrying epoch seconds and an error code.
// Depends on c2e_pkg.
interface c2e_out_if;
  import c2e_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/c2e_days.sv */
// First stage logic: field checks, day count and time-of-day seconds.
// Depends on c2e_pkg.
module c2e_days (
  input  c2e_pkg::in_item_t item,
  input  logic signed [4:0] zone_offset,
  output c2e_pkg::day_sum_t sum
);
  import c2e_pkg::*;

  logic               leap;
  logic [11:0]        yy;
  logic [11:0]        yoff;
  logic [9:0]         yquad;
  logic [19:0]        year_days;
  logic [4:0]         month_len;
  logic               bad_day;
  logic signed [6:0]  hour_adj;
  logic signed [19:0] hour_secs;
  logic [19:0]        ms_secs;
  err_code_t          code;

  always_comb begin
    leap = (item.year[1:0] == 2'b00);

    if (item.year >= EPOCH_YEAR) begin
      yy = item.year - CENTURY_BASE;
    end else if (item.year < TWO_DIGIT_LIM) begin
      yy = item.year + CENTURY_SPAN;
    end else begin
      yy = item.year;
    end
    // up to 2125 years past the base, so a full 12 bits
    yoff  = yy - BASE_YY;
    // (yy - 69) / 4
    yquad = 10'((yoff + 12'd1) >> 2);
    year_days = 20'(yoff) * DAYS_PER_YEAR + 20'(yquad);

    if (item.month == MONTH_FEB) begin
      month_len = leap ? 5'd29 : 5'd28;
    end else if (item.month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      month_len = 5'd30;
    end else begin
      month_len = 5'd31;
    end
    bad_day = (item.day == 5'd0) || (item.day > month_len);

    if (item.month < MONTH_JAN || item.month > MONTH_DEC) begin
      code = ERR_MONTH;
    end else if (bad_day) begin
      code = ERR_DAY;
    end else if (item.hour > MAX_HOUR) begin
      code = ERR_HOUR;
    end else if (item.minute > MAX_MINUTE) begin
      code = ERR_MINUTE;
    end else if (item.second > MAX_SECOND) begin
      code = ERR_SECOND;
    end else begin
      code = ERR_NONE;
    end

    // hour plus zone offset, minus one when DST is on
    hour_adj = $signed({2'b00, item.hour}) + $signed({{2{zone_offset[4]}}, zone_offset})
             - $signed({6'd0, item.dst_active});
    hour_secs = $signed({{13{hour_adj[6]}}, hour_adj}) * SECS_PER_HOUR;
    ms_secs   = 20'(item.minute) * SECS_PER_MIN + 20'(item.second);

    sum.day_count = year_days + 20'(days_before(item.month))
                  + 20'(leap && (item.month > MONTH_FEB)) + 20'(item.day) - 20'd1;
    sum.time_secs = hour_secs + $signed(ms_secs);
    sum.code      = code;
  end

endmodule

/* design/c2e_total.sv */
// Second stage logic: day count to seconds, final sum and negative check.
// Depends on c2e_pkg.
module c2e_total (
  input  c2e_pkg::day_sum_t  sum,
  output c2e_pkg::out_item_t result
);
  import c2e_pkg::*;

  logic [37:0]        day_secs;
  logic signed [37:0] total;

  always_comb begin
    day_secs = 38'(sum.day_count) * SECS_PER_DAY;
    total    = $signed(day_secs) + $signed({{18{sum.time_secs[19]}}, sum.time_secs});

    if (sum.code != ERR_NONE) begin
      result.epoch_seconds = '0;
      result.error_code    = sum.code;
    end else if (total[37]) begin
      result.epoch_seconds = '0;
      result.error_code    = ERR_NEGATIVE;
    end else begin
      result.epoch_seconds = total[36:0];
      result.error_code    = ERR_NONE;
    end
  end

endmodule

/* design/calendar_to_epoch_seconds.sv */
// Top level of the calendar to epoch seconds converter.
// Depends on c2e_pkg, c2e_in_if, c2e_out_if, c2e_days, c2e_total and the defines header.
`include "calendar_to_epoch_seconds_defines.svh"

// Converts a calendar date and time request into seconds since 1970-01-01.
// Each request returns exactly one result: epoch_seconds plus error_code
// (0 ok, 1 month, 2 day, 3 hour, 4 minute, 5 second, 6 negative total);
// on any error the seconds are zero. Years of 1970 and up have 1900
// subtracted, years below 70 mean 2000..2069, and a year is leap when its
// raw value is a multiple of four. The signed zone offset in hours
// (reset -1) is written through cfg_wr_en / cfg_wr_data and should only be
// changed with no request in flight. The datapath is three register stages
// (input, day count, result) that a request passes through in that order,
// and one request is accepted every cycle when the result side is ready;
// stages advance independently, so bubbles collapse.
// in_chan.ready falls only when all three stages hold data and the result
// is not being taken.
module calendar_to_epoch_seconds (
  input  logic              clk,
  input  logic              rst_n,
  c2e_in_if.sink            in_chan,
  c2e_out_if.source         out_chan,
  input  logic              cfg_wr_en,
  input  logic signed [4:0] cfg_wr_data
);
  import c2e_pkg::*;

  // zone offset register
  logic signed [4:0] zone_offset_r;

  // stage 1: captured request
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // stage 2: day count and time of day
  logic     s2_valid_r;
  day_sum_t s2_sum_r;
  day_sum_t s2_sum_nxt;

  // stage 3: result register
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  // per-stage load enables, chained back from the result side
  logic out_load;
  logic s2_load;
  logic s1_load;

  assign out_load = !out_valid_r || out_chan.ready;
  assign s2_load  = !s2_valid_r || out_load;
  assign s1_load  = !s1_valid_r || s2_load;

  assign in_chan.ready  = s1_load;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_offset_r <= ZONE_RESET;
    end else if (cfg_wr_en) begin
      zone_offset_r <= cfg_wr_data;
    end
  end

  c2e_days u_days (
    .item        (s1_item_r),
    .zone_offset (zone_offset_r),
    .sum         (s2_sum_nxt)
  );

  c2e_total u_total (
    .sum    (s2_sum_r),
    .result (out_item_nxt)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_load) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s1_load && in_chan.valid) begin
      s1_item_r <= in_chan.data;
    end
    if (s2_load && s1_valid_r) begin
      s2_sum_r <= s2_sum_nxt;
    end
    if (out_load && s2_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  // an error result never carries seconds
  `C2E_ASSERT_IMPLY(a_err_zero_secs, clk, rst_n, out_valid_r && (out_item_r.error_code != ERR_NONE), out_item_r.epoch_seconds == 37'd0, "error result with nonzero seconds")

  // back-pressure only when every stage is occupied
  `C2E_ASSERT_IMPLY(a_ready_full, clk, rst_n, !in_chan.ready, s1_valid_r && s2_valid_r && out_valid_r, "input stalled with a free stage")

  // a bad month in stage 1 reaches stage 2 as a month error
  `C2E_ASSERT_NEXT(a_month_err, clk, rst_n, s2_load && s1_valid_r && (s1_item_r.month == 4'd0 || s1_item_r.month > MONTH_DEC), s2_sum_r.code == ERR_MONTH, "bad month not flagged")

endmodule

/* tb/calendar_to_epoch_seconds_tb.sv */
`timescale 1ns / 100ps
// Testbench for calendar_to_epoch_seconds: directed and random date/time requests,
// each result checked against a table value or epoch predictor, across zone offsets.
// Depends on c2e_pkg, c2e_in_if, c2e_out_if and the calendar_to_epoch_seconds RTL.
module calendar_to_epoch_seconds_tb;
  import c2e_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int NUM_DIRECTED   = 25;
  localparam int NUM_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 212;
  // three register stages; extra pause once the last result is taken
  localparam int DRAIN_CYCLES   = 6;
  localparam longint DAY_SECS   = 86400;
  localparam longint HOUR_SECS  = 3600;

  // one directed row: the request and, where it is obvious, the result
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t result;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic signed [4:0] cfg_wr_data;

  c2e_in_if  in_chan ();
  c2e_out_if out_chan ();

  calendar_to_epoch_seconds DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // zone offset as the block should hold it right now
  logic signed [4:0] zone_hours = ZONE_RESET;

  // results still owed by the block, oldest first
  out_item_t expected_epochs [$];

  int mismatch_count = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int zones_used     = 1;
  int code_hits [0:6] = '{default: 0};
  int cycle_count    = 0;

  // no-idle stretches for either side
  int send_burst = 0;
  int take_burst = 0;

  // days in the year ahead of each month, non-leap
  longint days_ahead [1:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // Directed part. Zone is still the reset value (-1 hour) here.
  // Rows with typed=1 carry a result that is plain from the rules: the
  // zero and negative totals at the epoch, and the error codes including
  // check order when several fields are bad at once.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // epoch exactly: 01:00 minus one zone hour is zero
    '{'{12'd1970, 4'd1, 5'd1, 5'd1, 6'd0, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_NONE}},
    // midnight at the epoch goes below zero through the zone offset
    '{'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_NEGATIVE}},
    // two-digit 70 maps to 1970; daylight hour pushes it negative
    '{'{12'd70, 4'd1, 5'd1, 5'd1, 6'd0, 6'd0, 1'b1}, 1'b1, '{37'd0, ERR_NEGATIVE}},
    '{'{12'd70, 4'd1, 5'd1, 5'd2, 6'd0, 6'd0, 1'b1}, 1'b1, '{37'd0, ERR_NONE}},
    // month checked first even when everything else is bad too
    '{'{12'd0, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63, 1'b1}, 1'b1, '{37'd0, ERR_MONTH}},
    '{'{12'd2024, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_MONTH}},
    '{'{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b1}, 1'b1, '{37'd0, ERR_MONTH}},
    // day zero wins over a bad hour
    '{'{12'd2024, 4'd1, 5'd0, 5'd31, 6'd0, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_DAY}},
    '{'{12'd2023, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_DAY}},
    '{'{12'd1999, 4'd11, 5'd31, 5'd0, 6'd0, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_DAY}},
    // February: 29 only in a leap year, never 30
    '{'{12'd2001, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_DAY}},
    '{'{12'd2000, 4'd2, 5'd30, 5'd0, 6'd0, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_DAY}},
    '{'{12'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 1'b0}, 1'b0, '{37'd0, ERR_NONE}},
    // 1900 is leap by the raw-year rule and is not remapped
    '{'{12'd1900, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0, 1'b0}, 1'b0, '{37'd0, ERR_NONE}},
    // time fields; hour and minute errors each with a later field also bad
    '{'{12'd2010, 4'd6, 5'd15, 5'd24, 6'd63, 6'd0, 1'b0}, 1'b1, '{37'd0, ERR_HOUR}},
    '{'{12'd2010, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63, 1'b0}, 1'b1, '{37'd0, ERR_HOUR}},
    '{'{12'd2010, 4'd6, 5'd15, 5'd23, 6'd60, 6'd63, 1'b0}, 1'b1, '{37'd0, ERR_MINUTE}},
    '{'{12'd2010, 4'd6, 5'd15, 5'd23, 6'd59, 6'd60, 1'b0}, 1'b1, '{37'd0, ERR_SECOND}},
    '{'{12'd2010, 4'd6, 5'd15, 5'd23, 6'd59, 6'd63, 1'b1}, 1'b1, '{37'd0, ERR_SECOND}},
    // largest total the fields allow
    '{'{12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}, 1'b0, '{37'd0, ERR_NONE}},
    // year mapping edges: 69 is 2069, 99 is 1999, 1969 used as it stands
    '{'{12'd69, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}, 1'b0, '{37'd0, ERR_NONE}},
    '{'{12'd99, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}, 1'b0, '{37'd0, ERR_NONE}},
    '{'{12'd1969, 4'd7, 5'd20, 5'd20, 6'd17, 6'd40, 1'b1}, 1'b0, '{37'd0, ERR_NONE}},
    '{'{12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}, 1'b0, '{37'd0, ERR_NONE}},
    '{'{12'd2024, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 1'b0}, 1'b0, '{37'd0, ERR_NONE}}
  };

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int days_in_month(logic [3:0] month, logic leap);
    case (month)
      MONTH_FEB: return leap ? 29 : 28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
      default: return 31;
    endcase
  endfunction

  // Expected result for one request under the given zone offset.
  function automatic out_item_t epoch_of(in_item_t req, logic signed [4:0] zone);
    longint yy;
    longint days;
    longint total;
    longint zone_l;
    logic leap;
    err_code_t code;
    out_item_t res;
    // leap test uses the raw year, before any remapping
    leap = (req.year[1:0] == 2'b00);
    yy = longint'(req.year);
    if (yy >= 1970)
      yy = yy - 1900;
    else if (yy < 70)
      yy = yy + 100;
    // yy is at least 70 here, so the division never sees a negative
    days = (yy - 70) * 365 + (yy - 69) / 4;
    code = ERR_NONE;
    if (req.month < MONTH_JAN || req.month > MONTH_DEC) begin
      code = ERR_MONTH;
    end else begin
      days = days + days_ahead[req.month];
      if (leap && req.month > MONTH_FEB)
        days = days + 1;
      if (req.day == 0 || req.day > days_in_month(req.month, leap))
        code = ERR_DAY;
      else if (req.hour > MAX_HOUR)
        code = ERR_HOUR;
      else if (req.minute > MAX_MINUTE)
        code = ERR_MINUTE;
      else if (req.second > MAX_SECOND)
        code = ERR_SECOND;
    end
    total = 0;
    if (code == ERR_NONE) begin
      zone_l = longint'(zone);
      total = (days + longint'(req.day) - 1) * DAY_SECS
            + (longint'(req.hour) + zone_l) * HOUR_SECS
            + longint'(req.minute) * 60 + longint'(req.second);
      if (req.dst_active)
        total = total - HOUR_SECS;
      if (total < 0) begin
        code = ERR_NEGATIVE;
        total = 0;
      end
    end
    res.epoch_seconds = total[36:0];
    res.error_code = code;
    return res;
  endfunction

  // Mostly well-formed dates with random content; the rest are near-epoch
  // cases for the negative check, single broken fields, and raw noise.
  function automatic in_item_t random_request();
    in_item_t req;
    int sel;
    int len;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      req.year       = 12'($urandom_range(0, 4095));
      req.month      = 4'($urandom_range(0, 15));
      req.day        = 5'($urandom_range(0, 31));
      req.hour       = 5'($urandom_range(0, 31));
      req.minute     = 6'($urandom_range(0, 63));
      req.second     = 6'($urandom_range(0, 63));
      req.dst_active = 1'($urandom_range(0, 1));
      return req;
    end
    case ($urandom_range(0, 3))
      0: req.year = 12'($urandom_range(0, 99));
      1: req.year = 12'($urandom_range(1970, 2100));
      2: req.year = 12'($urandom_range(70, 1969));
      default: req.year = 12'($urandom_range(0, 4095));
    endcase
    req.month      = 4'($urandom_range(1, 12));
    len            = days_in_month(req.month, req.year[1:0] == 2'b00);
    req.day        = 5'($urandom_range(1, len));
    req.hour       = 5'($urandom_range(0, 23));
    req.minute     = 6'($urandom_range(0, 59));
    req.second     = 6'($urandom_range(0, 59));
    req.dst_active = 1'($urandom_range(0, 1));
    if (sel < 20) begin
      // first hours after the epoch, where the zone can go negative
      req.year  = $urandom_range(0, 1) ? 12'd70 : 12'd1970;
      req.month = MONTH_JAN;
      req.day   = 5'd1;
      req.hour  = 5'($urandom_range(0, 2));
    end else if (sel < 30) begin
      case ($urandom_range(0, 4))
        0: req.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
        1: req.day = (len == 31 || $urandom_range(0, 3) == 0) ?
                     5'd0 : 5'($urandom_range(len + 1, 31));
        2: req.hour = 5'($urandom_range(24, 31));
        3: req.minute = 6'($urandom_range(60, 63));
        default: req.second = 6'($urandom_range(60, 63));
      endcase
    end
    return req;
  endfunction

  // Idle cycles before the next handshake, drawn at random, except inside
  // a burst where the side stays busy back to back.
  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0)
      burst_left = $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  // Present one request at a falling edge and hold it until taken. Valid is
  // only lowered when a gap is drawn, so a back-to-back request never sees
  // valid dropped and raised in the same step.
  task automatic send_request(in_item_t req, out_item_t result);
    int gap;
    gap = draw_gap(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= req;
    do @(posedge clk); while (!in_chan.ready);
    expected_epochs.push_back(result);
    requests_sent++;
  endtask

  // Zone register change: only with the pipeline empty.
  task automatic write_zone(logic signed [4:0] value);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    zone_hours = value;
    zones_used++;
  endtask

  // Result side: ready toggles with random stalls, changed at falling edges.
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(take_burst);
      @(negedge clk);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Result checker: every taken result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (out_chan.data.error_code <= ERR_NEGATIVE)
        code_hits[out_chan.data.error_code]++;
      if (expected_epochs.size() == 0) begin
        $error("unexpected result: epoch_seconds %0d error_code %0d",
               out_chan.data.epoch_seconds, out_chan.data.error_code);
        mismatch_count++;
      end else begin
        want = expected_epochs.pop_front();
        if (out_chan.data.epoch_seconds !== want.epoch_seconds) begin
          $error("epoch_seconds: expected %0d, got %0d",
                 want.epoch_seconds, out_chan.data.epoch_seconds);
          mismatch_count++;
        end
        if (out_chan.data.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d",
                 want.error_code, out_chan.data.error_code);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_epochs.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus: directed table at the reset zone, then random phases, each
  // under its own zone offset. The full 5-bit range ends (-16, +15) are used
  // as well as the nominal -12..+14 span.
  initial begin
    logic signed [4:0] zone_plan [NUM_PHASES];
    in_item_t req;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    zone_plan = '{-5'sd16, 5'sd15, -5'sd12, 5'sd14, 5'sd0, 5'sd0, 5'sd0, -5'sd1};
    zone_plan[5] = 5'($urandom_range(0, 31));
    zone_plan[6] = 5'($urandom_range(0, 31));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req,
                   directed_rows[i].typed ? directed_rows[i].result
                                          : epoch_of(directed_rows[i].req, zone_hours));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_zone(zone_plan[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req = random_request();
        send_request(req, epoch_of(req, zone_hours));
      end
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d directed) under %0d zone settings, %0d results checked",
             requests_sent, NUM_DIRECTED, zones_used, results_seen);
    $display("codes seen: ok %0d, month %0d, day %0d, hour %0d, minute %0d, second %0d, neg %0d",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3],
             code_hits[4], code_hits[5], code_hits[6]);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
